@@ rtl/turing_machine_stepper_top_defines.svh @@
// Assertion macros for the Turing machine stepper checker.
// Needs signals named clk and arst_n in the scope that uses them.
`ifndef TURING_MACHINE_STEPPER_TOP_DEFINES_SVH
`define TURING_MACHINE_STEPPER_TOP_DEFINES_SVH

// same-cycle implication, off while in reset
`define TMS_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tms check failed");

// next-cycle implication, off while in reset
`define TMS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tms check failed");

`endif

@@ rtl/tms_pkg.sv @@
// Shared types and constants for the Turing machine stepper.
// No dependencies.
package tms_pkg;

	localparam int TAPE_DEPTH_DEF = 4096;
	localparam int RULE_SLOTS_DEF = 64;

	localparam int EPOCH_W    = 8;
	localparam int SYM_W      = 4;
	localparam int STATE_W    = 8;
	localparam int CELL_W     = 12;
	localparam int SLOT_W     = 6;
	localparam int MOVE_W     = 2;
	localparam int HEAD_OUT_W = 14;
	localparam int STEP_W     = 32;
	localparam int REQ_W      = 3;
	localparam int STATUS_W   = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int S_DATA_W   = 56;
	localparam int M_DATA_W   = 64;
	localparam int M_RSYM_LSB = 57;
	localparam int M_PAD_W    = M_DATA_W - M_RSYM_LSB - SYM_W;

	typedef enum logic [REQ_W-1:0] {
		REQ_LOAD_RULE  = 3'd0,
		REQ_WRITE_CELL = 3'd1,
		REQ_RESTART    = 3'd2,
		REQ_STEP       = 3'd3,
		REQ_READ_CELL  = 3'd4
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE    = 3'd0,
		ST_STEPPED = 3'd1,
		ST_HALTED  = 3'd2,
		ST_FUEL    = 3'd3,
		ST_RANGE   = 3'd4,
		ST_STUCK   = 3'd5
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_STATE = 3'd0,
		CFG_START_HEAD  = 3'd1,
		CFG_HALT_STATE  = 3'd2,
		CFG_BLANK       = 3'd3,
		CFG_FUEL_EN     = 3'd4,
		CFG_FUEL_LIMIT  = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		FSM_SWEEP,
		FSM_IDLE,
		FSM_CMD,
		FSM_CELL_RD,
		FSM_TAPE_RD,
		FSM_SCAN,
		FSM_RESP
	} fsm_t;

	typedef struct packed {
		logic               valid;
		logic [STATE_W-1:0] st;
		logic [SYM_W-1:0]   rd;
		logic [STATE_W-1:0] nx;
		logic [SYM_W-1:0]   wr;
		logic [MOVE_W-1:0]  mv;
	} rule_t;

	typedef struct packed {
		logic [EPOCH_W-1:0] tag;
		logic [SYM_W-1:0]   sym;
	} tape_ent_t;

	localparam int RULE_W = $bits(rule_t);
	localparam int TAPE_W = $bits(tape_ent_t);

endpackage

@@ rtl/tms_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module tms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/turing_machine_stepper_top.sv @@
// Turing machine stepper: one request word in, one result word out.
// Load rule and write cell act in the command state; restart too, unless the epoch wraps. Read cell
// adds a tape read; a step that is not halted, out of fuel or off the tape reads the tape, then scans
// the rule RAM one slot a cycle. One request is in flight at a time. Reset: s_tready stays low
// while tape tags and rule valid bits are swept; a wrapping restart sweeps only the tape tags again.
// Uses tms_pkg and tms_ram.
module turing_machine_stepper_top
	import tms_pkg::*;
#(
	parameter int TAPE_DEPTH = TAPE_DEPTH_DEF,
	parameter int RULE_SLOTS = RULE_SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// rule_slot, rule_state, rule_read, rule_next, rule_write, rule_move,
	// rule_enable, cell_address, cell_symbol, zero pad
	input  logic [S_DATA_W-1:0]   s_tdata,
	// req_type
	input  logic [REQ_W-1:0]      s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// status, machine_state, head_position, step_count, read_symbol, zero pad
	output logic [M_DATA_W-1:0]   m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW      = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1;
	localparam int RW      = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
	localparam int HEAD_W  = ((AW > CELL_W) ? AW : CELL_W) + 2;
	localparam int SWEEP_N = (TAPE_DEPTH > RULE_SLOTS) ? TAPE_DEPTH : RULE_SLOTS;
	localparam int SW      = (SWEEP_N > 1) ? $clog2(SWEEP_N) : 1;

	// config
	logic [STATE_W-1:0] start_state_q;
	logic [CELL_W-1:0]  start_head_q;
	logic [STATE_W-1:0] halt_state_q;
	logic [SYM_W-1:0]   blank_q;
	logic               fuel_en_q;
	logic [STEP_W-1:0]  fuel_limit_q;

	// request
	logic [REQ_W-1:0]   req_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [STATE_W-1:0] r_state_q;
	logic [SYM_W-1:0]   r_read_q;
	logic [STATE_W-1:0] r_next_q;
	logic [SYM_W-1:0]   r_write_q;
	logic [MOVE_W-1:0]  r_move_q;
	logic               r_en_q;
	logic [CELL_W-1:0]  addr_q;
	logic [SYM_W-1:0]   csym_q;

	// machine
	fsm_t               fsm_q, fsm_d;
	logic [STATE_W-1:0] cur_state_q;
	logic [HEAD_W-1:0]  head_q;
	logic [STEP_W-1:0]  steps_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [SW-1:0]      sweep_q;
	logic               sweep_rules_q;
	logic [RW-1:0]      idx_q;
	logic [SYM_W-1:0]   sym_q;
	status_t            status_q;
	logic [SYM_W-1:0]   rsym_q;
	logic               m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;

	// memory ports
	logic          tape_we;
	logic [AW-1:0] tape_waddr, tape_raddr;
	tape_ent_t     tape_wdata, tape_rd;
	logic          rule_we;
	logic [RW-1:0] rule_waddr, rule_raddr;
	rule_t         rule_wdata, rule_rd;

	logic              accept, out_free, sweep_done, epoch_wrap;
	logic              cell_in_range, slot_in_range, head_in_range;
	logic              halted, fuel_out, rule_match, scan_last;
	logic [SYM_W-1:0]  tape_sym;
	logic [MOVE_W-1:0] move_norm;
	logic [HEAD_W-1:0] head_next;

	tms_ram #(.WIDTH(TAPE_W), .DEPTH(TAPE_DEPTH)) u_tape (
		.clk   (clk),
		.we    (tape_we),
		.waddr (tape_waddr),
		.wdata (tape_wdata),
		.raddr (tape_raddr),
		.rdata (tape_rd)
	);

	tms_ram #(.WIDTH(RULE_W), .DEPTH(RULE_SLOTS)) u_rules (
		.clk   (clk),
		.we    (rule_we),
		.waddr (rule_waddr),
		.wdata (rule_wdata),
		.raddr (rule_raddr),
		.rdata (rule_rd)
	);

	assign s_tready = (fsm_q == FSM_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign sweep_done    = (sweep_q == SW'(SWEEP_N - 1));
	assign epoch_wrap    = (epoch_q == {EPOCH_W{1'b1}});
	assign cell_in_range = (32'(addr_q) < 32'(TAPE_DEPTH));
	assign slot_in_range = (32'(slot_q) < 32'(RULE_SLOTS));
	assign head_in_range = !head_q[HEAD_W-1] && (head_q < HEAD_W'(TAPE_DEPTH));
	assign halted        = (cur_state_q == halt_state_q);
	assign fuel_out      = fuel_en_q && (steps_q >= fuel_limit_q);
	// tag from an earlier restart means the cell is blank
	assign tape_sym      = (tape_rd.tag == epoch_q) ? tape_rd.sym : blank_q;
	assign rule_match    = rule_rd.valid && (rule_rd.st == cur_state_q) &&
	                       (rule_rd.rd == sym_q);
	assign scan_last     = (idx_q == RW'(RULE_SLOTS - 1));
	assign head_next     = head_q + {{(HEAD_W - MOVE_W){rule_rd.mv[MOVE_W-1]}}, rule_rd.mv};
	// code 10 acts as stay
	assign move_norm     = (r_move_q == 2'b01 || r_move_q == 2'b11) ? r_move_q : 2'b00;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q <= FSM_SWEEP;
		end else begin
			fsm_q <= fsm_d;
		end
	end

	always_comb begin
		fsm_d      = fsm_q;
		tape_we    = 1'b0;
		tape_waddr = head_q[AW-1:0];
		tape_wdata = '{tag: epoch_q, sym: rule_rd.wr};
		tape_raddr = head_q[AW-1:0];
		rule_we    = 1'b0;
		rule_waddr = RW'(32'(slot_q));
		rule_wdata = '{valid: r_en_q, st: r_state_q, rd: r_read_q, nx: r_next_q,
		               wr: r_write_q, mv: move_norm};
		rule_raddr = idx_q + RW'(1);
		unique case (fsm_q)
			FSM_SWEEP: begin
				tape_we    = (32'(sweep_q) < 32'(TAPE_DEPTH));
				tape_waddr = sweep_q[AW-1:0];
				tape_wdata = '0;
				rule_we    = sweep_rules_q && (32'(sweep_q) < 32'(RULE_SLOTS));
				rule_waddr = sweep_q[RW-1:0];
				rule_wdata = '0;
				if (sweep_done) begin
					fsm_d = sweep_rules_q ? FSM_IDLE : FSM_RESP;
				end
			end
			FSM_IDLE: begin
				if (s_tvalid) begin
					fsm_d = FSM_CMD;
				end
			end
			FSM_CMD: begin
				unique case (req_q)
					REQ_LOAD_RULE: begin
						rule_we = slot_in_range;
						fsm_d   = FSM_RESP;
					end
					REQ_WRITE_CELL: begin
						tape_we    = cell_in_range;
						tape_waddr = AW'(32'(addr_q));
						tape_wdata = '{tag: epoch_q, sym: csym_q};
						fsm_d      = FSM_RESP;
					end
					REQ_RESTART: begin
						fsm_d = epoch_wrap ? FSM_SWEEP : FSM_RESP;
					end
					REQ_STEP: begin
						if (halted || fuel_out || !head_in_range) begin
							fsm_d = FSM_RESP;
						end else begin
							fsm_d = FSM_TAPE_RD;
						end
					end
					REQ_READ_CELL: begin
						tape_raddr = AW'(32'(addr_q));
						fsm_d      = FSM_CELL_RD;
					end
					default: begin
						fsm_d = FSM_RESP;
					end
				endcase
			end
			FSM_CELL_RD: begin
				fsm_d = FSM_RESP;
			end
			FSM_TAPE_RD: begin
				rule_raddr = '0;
				fsm_d      = FSM_SCAN;
			end
			FSM_SCAN: begin
				if (rule_match) begin
					tape_we = 1'b1;
					fsm_d   = FSM_RESP;
				end else if (scan_last) begin
					fsm_d = FSM_RESP;
				end
			end
			FSM_RESP: begin
				if (out_free) begin
					fsm_d = FSM_IDLE;
				end
			end
			default: begin
				fsm_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_state_q <= '0;
			start_head_q  <= '0;
			halt_state_q  <= '1;
			blank_q       <= '0;
			fuel_en_q     <= 1'b0;
			fuel_limit_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_START_STATE: start_state_q <= cfg_data[STATE_W-1:0];
				CFG_START_HEAD:  start_head_q  <= cfg_data[CELL_W-1:0];
				CFG_HALT_STATE:  halt_state_q  <= cfg_data[STATE_W-1:0];
				CFG_BLANK:       blank_q       <= cfg_data[SYM_W-1:0];
				CFG_FUEL_EN:     fuel_en_q     <= cfg_data[0];
				CFG_FUEL_LIMIT:  fuel_limit_q  <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_state_q   <= '0;
			head_q        <= '0;
			steps_q       <= '0;
			epoch_q       <= EPOCH_W'(1);
			sweep_q       <= '0;
			sweep_rules_q <= 1'b1;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (fsm_q == FSM_SWEEP) begin
				if (sweep_done) begin
					sweep_q       <= '0;
					sweep_rules_q <= 1'b0;
				end else begin
					sweep_q <= sweep_q + SW'(1);
				end
			end
			if (fsm_q == FSM_CMD && req_q == REQ_RESTART) begin
				cur_state_q <= start_state_q;
				head_q      <= HEAD_W'(start_head_q);
				steps_q     <= '0;
				epoch_q     <= epoch_wrap ? EPOCH_W'(1) : epoch_q + EPOCH_W'(1);
			end
			if (fsm_q == FSM_SCAN && rule_match) begin
				cur_state_q <= rule_rd.nx;
				head_q      <= head_next;
				if (steps_q != '1) begin
					steps_q <= steps_q + STEP_W'(1);
				end
			end
			if (fsm_q == FSM_RESP && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q     <= s_tuser;
			slot_q    <= s_tdata[5:0];
			r_state_q <= s_tdata[13:6];
			r_read_q  <= s_tdata[17:14];
			r_next_q  <= s_tdata[25:18];
			r_write_q <= s_tdata[29:26];
			r_move_q  <= s_tdata[31:30];
			r_en_q    <= s_tdata[32];
			addr_q    <= s_tdata[44:33];
			csym_q    <= s_tdata[48:45];
		end
		if (fsm_q == FSM_CMD) begin
			rsym_q <= '0;
			if (req_q == REQ_STEP && halted) begin
				status_q <= ST_HALTED;
			end else if (req_q == REQ_STEP && fuel_out) begin
				status_q <= ST_FUEL;
			end else if (req_q == REQ_STEP && !head_in_range) begin
				status_q <= ST_RANGE;
			end else begin
				status_q <= ST_DONE;
			end
		end
		if (fsm_q == FSM_CELL_RD) begin
			rsym_q <= cell_in_range ? tape_sym : blank_q;
		end
		if (fsm_q == FSM_TAPE_RD) begin
			sym_q <= tape_sym;
			idx_q <= '0;
		end
		if (fsm_q == FSM_SCAN) begin
			idx_q <= idx_q + RW'(1);
			if (rule_match) begin
				status_q <= ST_STEPPED;
			end else if (scan_last) begin
				status_q <= ST_STUCK;
			end
		end
		if (fsm_q == FSM_RESP && out_free) begin
			m_tdata_q <= {{M_PAD_W{1'b0}}, rsym_q, steps_q, head_q[HEAD_OUT_W-1:0],
			              cur_state_q, status_q};
		end
	end

endmodule

@@ rtl/tms_checker.sv @@
// Port-level checks for the Turing machine stepper, bound to the top level.
// Uses tms_pkg and turing_machine_stepper_top_defines.svh.
`include "turing_machine_stepper_top_defines.svh"

module tms_checker
	import tms_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata
);

	logic [STATUS_W-1:0] res_status;
	logic [SYM_W-1:0]    res_rsym;

	assign res_status = m_tdata[STATUS_W-1:0];
	assign res_rsym   = m_tdata[M_RSYM_LSB+SYM_W-1:M_RSYM_LSB];

	`TMS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`TMS_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
	`TMS_ASSERT_IMPL(a_status_code, m_tvalid, res_status <= ST_STUCK)
	`TMS_ASSERT_IMPL(a_rsym_on_done, m_tvalid && (res_status != ST_DONE), res_rsym == '0)

endmodule

bind turing_machine_stepper_top tms_checker u_tms_checker (.*);
